// ----- src/asls_pkg.sv -----
// Shared types and constants for the activity status LED sequencer.
package asls_pkg;

    // Operating modes, as reported in mode_now.
    localparam logic [1:0] MODE_ACTIVE = 2'd0;
    localparam logic [1:0] MODE_IDLE   = 2'd1;
    localparam logic [1:0] MODE_FLASH  = 2'd2;
    localparam logic [1:0] MODE_ASLEEP = 2'd3;

    // Command codes carried in the input transaction.
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_ACTIVITY = 2'd1;
    localparam logic [1:0] CMD_LINK     = 2'd2;

    // Activity codes for an activity change.
    localparam logic [1:0] ACT_ACTIVE = 2'd0;
    localparam logic [1:0] ACT_IDLE   = 2'd1;
    localparam logic [1:0] ACT_SLEEP  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_ON     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_OFF    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_COUNT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_ON    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_OFF   = 3'd4;

    // Register reset values.
    localparam logic [15:0] IDLE_ON_RST     = 16'd1000;
    localparam logic [15:0] IDLE_OFF_RST    = 16'd2000;
    localparam logic [3:0]  FLASH_COUNT_RST = 4'd3;
    localparam logic [15:0] FLASH_ON_RST    = 16'd80;
    localparam logic [15:0] FLASH_OFF_RST   = 16'd80;

    // Current configuration.
    typedef struct packed {
        logic [15:0] idle_on_ms;
        logic [15:0] idle_off_ms;
        logic [3:0]  flash_count;
        logic [15:0] flash_on_ms;
        logic [15:0] flash_off_ms;
    } cfg_t;

    // Sequencer state.
    typedef struct packed {
        logic [1:0]  mode;
        logic        lit_phase;
        logic [15:0] ticks_left;
        logic [3:0]  flashes_left;
        logic        power_lit;
        logic        link_lit;
    } seq_state_t;

endpackage

// ----- src/asls_cfg_regs.sv -----
// Configuration register file of the LED sequencer.
module asls_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [asls_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [asls_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output asls_pkg::cfg_t                    cfg
);

    asls_pkg::cfg_t cfg_reg;

    // Write decode; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_on_ms   <= asls_pkg::IDLE_ON_RST;
            cfg_reg.idle_off_ms  <= asls_pkg::IDLE_OFF_RST;
            cfg_reg.flash_count  <= asls_pkg::FLASH_COUNT_RST;
            cfg_reg.flash_on_ms  <= asls_pkg::FLASH_ON_RST;
            cfg_reg.flash_off_ms <= asls_pkg::FLASH_OFF_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                asls_pkg::REG_IDLE_ON:     cfg_reg.idle_on_ms   <= cfg_wdata;
                asls_pkg::REG_IDLE_OFF:    cfg_reg.idle_off_ms  <= cfg_wdata;
                asls_pkg::REG_FLASH_COUNT: cfg_reg.flash_count  <= cfg_wdata[3:0];
                asls_pkg::REG_FLASH_ON:    cfg_reg.flash_on_ms  <= cfg_wdata;
                asls_pkg::REG_FLASH_OFF:   cfg_reg.flash_off_ms <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/asls_step.sv -----
// Next-state logic of the LED sequencer for one command.
module asls_step (
    input  asls_pkg::seq_state_t st,
    input  asls_pkg::cfg_t       cfg,
    input  logic [1:0]           cmd,
    input  logic [1:0]           activity,
    input  logic                 link_up,
    output asls_pkg::seq_state_t nxt
);

    logic [3:0] flashes_dec;

    assign flashes_dec = st.flashes_left - 4'd1;

    always_comb begin
        nxt = st;
        unique case (cmd)
            // Millisecond tick: count down, act on expiry of the period.
            asls_pkg::CMD_TICK: begin
                if (st.mode == asls_pkg::MODE_IDLE || st.mode == asls_pkg::MODE_FLASH) begin
                    if (st.ticks_left > 16'd1) begin
                        nxt.ticks_left = st.ticks_left - 16'd1;
                    end else if (st.mode == asls_pkg::MODE_IDLE) begin
                        nxt.lit_phase  = !st.lit_phase;
                        nxt.power_lit  = !st.lit_phase;
                        nxt.ticks_left = st.lit_phase ? cfg.idle_off_ms : cfg.idle_on_ms;
                    end else if (!st.lit_phase) begin
                        // End of a dark gap: next flash, or sleep if none remain.
                        if (st.flashes_left == 4'd0) begin
                            nxt.mode       = asls_pkg::MODE_ASLEEP;
                            nxt.power_lit  = 1'b0;
                            nxt.ticks_left = 16'd0;
                        end else begin
                            nxt.lit_phase  = 1'b1;
                            nxt.power_lit  = 1'b1;
                            nxt.ticks_left = cfg.flash_on_ms;
                        end
                    end else begin
                        // End of a flash; no gap follows the last one.
                        nxt.power_lit    = 1'b0;
                        nxt.lit_phase    = 1'b0;
                        nxt.flashes_left = flashes_dec;
                        if (flashes_dec == 4'd0) begin
                            nxt.mode       = asls_pkg::MODE_ASLEEP;
                            nxt.ticks_left = 16'd0;
                        end else begin
                            nxt.ticks_left = cfg.flash_off_ms;
                        end
                    end
                end
            end
            // Activity change restarts the named mode.
            asls_pkg::CMD_ACTIVITY: begin
                unique case (activity)
                    asls_pkg::ACT_ACTIVE: begin
                        nxt.mode         = asls_pkg::MODE_ACTIVE;
                        nxt.power_lit    = 1'b1;
                        nxt.link_lit     = link_up;
                        nxt.lit_phase    = 1'b0;
                        nxt.ticks_left   = 16'd0;
                        nxt.flashes_left = 4'd0;
                    end
                    asls_pkg::ACT_IDLE: begin
                        nxt.mode         = asls_pkg::MODE_IDLE;
                        nxt.link_lit     = 1'b0;
                        nxt.lit_phase    = 1'b1;
                        nxt.power_lit    = 1'b1;
                        nxt.ticks_left   = cfg.idle_on_ms;
                        nxt.flashes_left = 4'd0;
                    end
                    asls_pkg::ACT_SLEEP: begin
                        nxt.mode         = asls_pkg::MODE_FLASH;
                        nxt.power_lit    = 1'b0;
                        nxt.link_lit     = 1'b0;
                        nxt.lit_phase    = 1'b0;
                        nxt.ticks_left   = cfg.flash_off_ms;
                        nxt.flashes_left = cfg.flash_count;
                    end
                    default: begin
                    end
                endcase
            end
            // Link change only shows while active.
            asls_pkg::CMD_LINK: begin
                if (st.mode == asls_pkg::MODE_ACTIVE) begin
                    nxt.link_lit = link_up;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- src/activity_status_led_sequencer_core.sv -----
// Top level of the activity status LED sequencer.
//
//  Channel  | Ports                     | Contents
//  ---------+---------------------------+-----------------------------------------
//  input    | s_tvalid s_tready s_tdata | tuser: cmd; tdata: activity, link_up
//  result   | m_tvalid m_tready m_tdata | tdata: power_led, link_led, mode_now
//  config   | cfg_we cfg_addr cfg_wdata | register write, no read-back
//
// Each transaction is held in the input register until the result register is
// free and then moves there; one transaction per cycle is sustained while the
// result side keeps m_tready high.
// Reset (synchronous, active low) empties both registers and restores the
// state and configuration. A stalled result holds while one more input waits.
module activity_status_led_sequencer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [1:0] activity, [2] link_up
    input  logic [1:0]                      s_tuser,   // [1:0] cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [0] power_led, [1] link_led,
                                                       // [3:2] mode_now
    input  logic                            cfg_we,
    input  logic [asls_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [asls_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    asls_pkg::cfg_t       cfg;
    asls_pkg::seq_state_t state_reg;
    asls_pkg::seq_state_t state_next;

    logic       in_valid_reg;
    logic [1:0] cmd_reg;
    logic [1:0] activity_reg;
    logic       link_up_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       advance;

    asls_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    asls_step u_step (
        .st       (state_reg),
        .cfg      (cfg),
        .cmd      (cmd_reg),
        .activity (activity_reg),
        .link_up  (link_up_reg),
        .nxt      (state_next)
    );

    // The held transaction moves on when the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg      <= s_tuser;
            activity_reg <= s_tdata[1:0];
            link_up_reg  <= s_tdata[2];
        end
    end

    // Sequencer state advances once per transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode         <= asls_pkg::MODE_ACTIVE;
            state_reg.lit_phase    <= 1'b0;
            state_reg.ticks_left   <= 16'd0;
            state_reg.flashes_left <= 4'd0;
            state_reg.power_lit    <= 1'b1;
            state_reg.link_lit     <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {4'b0000, state_next.mode, state_next.link_lit,
                             state_next.power_lit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The link LED is dark in every mode but active.
    a_link_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.mode != asls_pkg::MODE_ACTIVE |-> !state_reg.link_lit)
        else $error("link LED lit outside the active mode");

    // Flashes are only pending during the flash sequence.
    a_flash_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.mode != asls_pkg::MODE_FLASH |-> state_reg.flashes_left == 4'd0)
        else $error("flashes pending outside the flash sequence");

    // A transaction held in the input register is not lost while the output stalls.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(cmd_reg))
        else $error("held input transaction dropped");

    // A reported sleep state always has both LEDs dark.
    a_sleep_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:2] == asls_pkg::MODE_ASLEEP |-> m_tdata[1:0] == 2'b00)
        else $error("LED lit while asleep");

endmodule
